FILE: design/ecmp_pkg.sv
`timescale 1ns / 1ps

package ecmp_pkg;

    localparam int HASH_W = 32;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int PROT_W = 8;
    localparam int PORT_W = 16;

    localparam int MAX_PATHS = 64;

    localparam int IN_BITS   = 2 * HASH_W + PROT_W + 2 * PORT_W + CNT_W;
    localparam int S_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = IDX_W + HASH_W;
    localparam int M_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam int HASH_STAGES    = 8;
    localparam int MOD_STAGES     = 4;
    localparam int BITS_PER_STAGE = HASH_W / MOD_STAGES;

    localparam logic [HASH_W-1:0] C1       = 32'hcc9e2d51;
    localparam logic [HASH_W-1:0] C2       = 32'h1b873593;
    localparam logic [HASH_W-1:0] MIX_ADD  = 32'he6546b64;
    localparam logic [HASH_W-1:0] F1       = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] F2       = 32'hc2b2ae35;
    localparam logic [HASH_W-1:0] KEY_BYTES = 32'd12;

    localparam logic [PROT_W-1:0] PROTO_TCP  = 8'h06;
    localparam logic [PROT_W-1:0] PROTO_UDP  = 8'h11;
    localparam logic [PROT_W-1:0] PROTO_ACK  = 8'hfc;
    localparam logic [PROT_W-1:0] PROTO_NACK = 8'hfd;

    typedef struct packed {
        logic [HASH_W-1:0] src_addr;
        logic [HASH_W-1:0] dst_addr;
        logic [PROT_W-1:0] l3_protocol;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic [CNT_W-1:0]  path_count;
    } hdr_t;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [CNT_W-1:0]  divisor;
        logic              no_route;
    } hash_item_t;

endpackage

FILE: design/ecmp_flow_hash_path_select.sv
// pipeline: an accepted request passes the hash stages and then the remainder stages to m_tvalid
// (8 hash stages, 4 remainder stages of 8 dividend bits each)
// throughput: one request per cycle while the output is not stalled, the stall chain refills bubbles
// reset: rst_n asynchronous active low, clears all valid bits and the seed
`timescale 1ns / 1ps

module ecmp_flow_hash_path_select
    import ecmp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [HASH_W-1:0]   cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // src_addr, dst_addr, l3_protocol, src_port, dst_port, path_count, zero pad
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // path_index, hash_value, zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // no_route
    output logic [0:0]          m_tuser
);

    logic [HASH_W-1:0] seed_reg;
    logic [HASH_W-1:0] seed_next;
    hdr_t              hdr;
    hash_item_t        hash_item;
    logic              hash_valid;
    logic              hash_ready;
    logic [IDX_W-1:0]  path_index;
    logic [HASH_W-1:0] hash_value;
    logic              no_route;

    assign seed_next = cfg_we ? cfg_wdata : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    assign hdr.src_addr    = s_tdata[31:0];
    assign hdr.dst_addr    = s_tdata[63:32];
    assign hdr.l3_protocol = s_tdata[71:64];
    assign hdr.src_port    = s_tdata[87:72];
    assign hdr.dst_port    = s_tdata[103:88];
    assign hdr.path_count  = s_tdata[110:104];

    ecmp_hash_pipe u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (seed_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hdr    (hdr),
        .out_valid (hash_valid),
        .out_ready (hash_ready),
        .out_item  (hash_item)
    );

    ecmp_mod_pipe u_mod (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (hash_valid),
        .in_ready   (hash_ready),
        .in_item    (hash_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .path_index (path_index),
        .hash_value (hash_value),
        .no_route   (no_route)
    );

    assign m_tdata    = {(M_DATA_W - OUT_BITS)'(0), hash_value, path_index};
    assign m_tuser[0] = no_route;

endmodule

FILE: design/ecmp_hash_pipe.sv
`timescale 1ns / 1ps

module ecmp_hash_pipe
    import ecmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [HASH_W-1:0] seed,
    input  logic              in_valid,
    output logic              in_ready,
    input  hdr_t              in_hdr,
    output logic              out_valid,
    input  logic              out_ready,
    output hash_item_t        out_item
);

    function automatic logic [HASH_W-1:0] mix_h(input logic [HASH_W-1:0] h,
                                               input logic [HASH_W-1:0] k);
        logic [HASH_W-1:0] x;
        x = h ^ k;
        x = {x[18:0], x[31:19]};
        return x + {x[29:0], 2'b00} + MIX_ADD;
    endfunction

    logic [HASH_STAGES-1:0] v_reg;
    logic [HASH_STAGES-1:0] en;

    logic [CNT_W-1:0]  cnt_reg [HASH_STAGES];
    logic              nr_reg  [HASH_STAGES];

    logic [HASH_W-1:0] s1_k_reg [3];
    logic [HASH_W-1:0] s2_k_reg [3];
    logic [HASH_W-1:0] s3_h_reg;
    logic [HASH_W-1:0] s3_k1_reg;
    logic [HASH_W-1:0] s3_k2_reg;
    logic [HASH_W-1:0] s4_h_reg;
    logic [HASH_W-1:0] s4_k2_reg;
    logic [HASH_W-1:0] s5_h_reg;
    logic [HASH_W-1:0] s6_f_reg;
    logic [HASH_W-1:0] s7_f_reg;
    logic [HASH_W-1:0] s8_h_reg;

    logic [HASH_W-1:0] ports_word;
    logic              uses_ports;
    logic              no_route_in;
    logic [CNT_W-1:0]  divisor_in;
    logic [HASH_W-1:0] fin0;
    logic [HASH_W-1:0] fin1;
    logic [HASH_W-1:0] s2_rot [3];

    // stall chain, a stage loads when empty or when its successor moves
    always_comb
    begin
        en[HASH_STAGES-1] = !v_reg[HASH_STAGES-1] || out_ready;
        for (int i = HASH_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        uses_ports = (in_hdr.l3_protocol == PROTO_TCP) || (in_hdr.l3_protocol == PROTO_UDP) ||
                     (in_hdr.l3_protocol == PROTO_ACK) || (in_hdr.l3_protocol == PROTO_NACK);
        ports_word = uses_ports ? {in_hdr.dst_port, in_hdr.src_port} : '0;
        no_route_in = (in_hdr.path_count == '0);
        if (no_route_in)
        begin
            divisor_in = CNT_W'(1);
        end
        else if (int'(in_hdr.path_count) > MAX_PATHS)
        begin
            divisor_in = CNT_W'(MAX_PATHS);
        end
        else
        begin
            divisor_in = in_hdr.path_count;
        end
        for (int w = 0; w < 3; w++)
        begin
            s2_rot[w] = {s1_k_reg[w][16:0], s1_k_reg[w][31:17]};
        end
        fin0 = s5_h_reg ^ KEY_BYTES;
        fin0 = fin0 ^ (fin0 >> 16);
        fin1 = s6_f_reg ^ (s6_f_reg >> 13);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < HASH_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cnt_reg[0]  <= divisor_in;
            nr_reg[0]   <= no_route_in;
            s1_k_reg[0] <= in_hdr.src_addr * C1;
            s1_k_reg[1] <= in_hdr.dst_addr * C1;
            s1_k_reg[2] <= ports_word * C1;
        end
        for (int i = 1; i < HASH_STAGES; i++)
        begin
            if (en[i])
            begin
                cnt_reg[i] <= cnt_reg[i-1];
                nr_reg[i]  <= nr_reg[i-1];
            end
        end
        if (en[1])
        begin
            for (int w = 0; w < 3; w++)
            begin
                s2_k_reg[w] <= s2_rot[w] * C2;
            end
        end
        if (en[2])
        begin
            s3_h_reg  <= mix_h(seed, s2_k_reg[0]);
            s3_k1_reg <= s2_k_reg[1];
            s3_k2_reg <= s2_k_reg[2];
        end
        if (en[3])
        begin
            s4_h_reg  <= mix_h(s3_h_reg, s3_k1_reg);
            s4_k2_reg <= s3_k2_reg;
        end
        if (en[4])
        begin
            s5_h_reg <= mix_h(s4_h_reg, s4_k2_reg);
        end
        if (en[5])
        begin
            s6_f_reg <= fin0 * F1;
        end
        if (en[6])
        begin
            s7_f_reg <= fin1 * F2;
        end
        if (en[7])
        begin
            s8_h_reg <= s7_f_reg ^ (s7_f_reg >> 16);
        end
    end

    assign out_valid        = v_reg[HASH_STAGES-1];
    assign out_item.hash     = s8_h_reg;
    assign out_item.divisor  = cnt_reg[HASH_STAGES-1];
    assign out_item.no_route = nr_reg[HASH_STAGES-1];

endmodule

FILE: design/ecmp_mod_pipe.sv
`timescale 1ns / 1ps

module ecmp_mod_pipe
    import ecmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hash_item_t       in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [IDX_W-1:0] path_index,
    output logic [HASH_W-1:0] hash_value,
    output logic             no_route
);

    // restoring remainder, one dividend bit per step
    function automatic logic [CNT_W-1:0] rem_step(input logic [CNT_W-1:0] r_in,
                                                 input logic [BITS_PER_STAGE-1:0] bits,
                                                 input logic [CNT_W-1:0] d);
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        r = r_in;
        for (int b = BITS_PER_STAGE - 1; b >= 0; b--)
        begin
            t = {r, bits[b]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            r = t[CNT_W-1:0];
        end
        return r;
    endfunction

    logic [MOD_STAGES-1:0] v_reg;
    logic [MOD_STAGES-1:0] en;

    logic [CNT_W-1:0]  r_reg  [MOD_STAGES];
    logic [HASH_W-1:0] h_reg  [MOD_STAGES];
    logic [CNT_W-1:0]  d_reg  [MOD_STAGES];
    logic              nr_reg [MOD_STAGES];

    logic [CNT_W-1:0]  r_in  [MOD_STAGES];
    logic [HASH_W-1:0] h_in  [MOD_STAGES];
    logic [CNT_W-1:0]  d_in  [MOD_STAGES];
    logic              nr_in [MOD_STAGES];

    always_comb
    begin
        en[MOD_STAGES-1] = !v_reg[MOD_STAGES-1] || out_ready;
        for (int i = MOD_STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_comb
    begin
        r_in[0]  = '0;
        h_in[0]  = in_item.hash;
        d_in[0]  = in_item.divisor;
        nr_in[0] = in_item.no_route;
        for (int j = 1; j < MOD_STAGES; j++)
        begin
            r_in[j]  = r_reg[j-1];
            h_in[j]  = h_reg[j-1];
            d_in[j]  = d_reg[j-1];
            nr_in[j] = nr_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < MOD_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MOD_STAGES; j++)
        begin
            if (en[j])
            begin
                r_reg[j]  <= rem_step(r_in[j],
                                      h_in[j][HASH_W-1-j*BITS_PER_STAGE -: BITS_PER_STAGE],
                                      d_in[j]);
                h_reg[j]  <= h_in[j];
                d_reg[j]  <= d_in[j];
                nr_reg[j] <= nr_in[j];
            end
        end
    end

    assign out_valid  = v_reg[MOD_STAGES-1];
    assign hash_value = h_reg[MOD_STAGES-1];
    assign no_route   = nr_reg[MOD_STAGES-1];
    assign path_index = nr_reg[MOD_STAGES-1] ? '0 : r_reg[MOD_STAGES-1][IDX_W-1:0];

endmodule

FILE: design/ecmp_checker.sv
`timescale 1ns / 1ps

module ecmp_checker
    import ecmp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // dropped packets select no path
    a_drop_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[IDX_W-1:0] == '0)
        else $error("path index set on a dropped packet");

    // an open output keeps the input open
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

    // nothing leaves the block during reset
    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // padding bits stay clear
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_DATA_W-1:OUT_BITS] == '0)
        else $error("padding bits set on result");

endmodule

bind ecmp_flow_hash_path_select ecmp_checker u_ecmp_checker (.*);

FILE: tb/sv/tb_ecmp_flow_hash_path_select.sv
`timescale 1ns / 1ps

module tb_ecmp_flow_hash_path_select;

    import ecmp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 96;

    typedef struct {
        logic [IDX_W-1:0]  path_index;
        logic [HASH_W-1:0] hash_value;
        logic              no_route;
    } path_choice_t;

    class path_choice_tracker;
        logic [HASH_W-1:0] seed = '0;
        path_choice_t      pending_choices[$];
        int                mismatches = 0;
        int                requests = 0;
        int                choices = 0;
        int                dropped = 0;
        int                portless = 0;

        function automatic logic [HASH_W-1:0] rotl(logic [HASH_W-1:0] v, int r);
            return (v << r) | (v >> (HASH_W - r));
        endfunction

        function automatic logic [HASH_W-1:0] mix_word(logic [HASH_W-1:0] h,
                                                       logic [HASH_W-1:0] k);
            k = k * C1;
            k = rotl(k, 15);
            k = k * C2;
            h = h ^ k;
            h = rotl(h, 13);
            h = h * 32'd5 + MIX_ADD;
            return h;
        endfunction

        function automatic logic [HASH_W-1:0] flow_hash(hdr_t hd);
            logic [HASH_W-1:0] h;
            logic [HASH_W-1:0] ports;
            ports = '0;
            if (hd.l3_protocol == PROTO_TCP || hd.l3_protocol == PROTO_UDP ||
                hd.l3_protocol == PROTO_ACK || hd.l3_protocol == PROTO_NACK)
                ports = {hd.dst_port, hd.src_port};
            h = seed;
            h = mix_word(h, hd.src_addr);
            h = mix_word(h, hd.dst_addr);
            h = mix_word(h, ports);
            h = h ^ KEY_BYTES;
            h = h ^ (h >> 16);
            h = h * F1;
            h = h ^ (h >> 13);
            h = h * F2;
            h = h ^ (h >> 16);
            return h;
        endfunction

        function void note_request(hdr_t hd);
            path_choice_t c;
            logic [HASH_W-1:0] divisor;
            logic [HASH_W-1:0] rem;
            c.hash_value = flow_hash(hd);
            c.no_route = (hd.path_count == '0);
            c.path_index = '0;
            if (!c.no_route)
            begin
                divisor = (hd.path_count > MAX_PATHS) ? MAX_PATHS : hd.path_count;
                rem = c.hash_value % divisor;
                c.path_index = rem[IDX_W-1:0];
            end
            if (c.no_route)
                dropped++;
            if (!(hd.l3_protocol inside {PROTO_TCP, PROTO_UDP, PROTO_ACK, PROTO_NACK}))
                portless++;
            requests++;
            pending_choices.insert(pending_choices.size(), c);
        endfunction

        function void flag(string what, logic [HASH_W-1:0] want, logic [HASH_W-1:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at result %0d: expected %h, got %h",
                         what, choices, want, got);
        endfunction

        function void check_choice(logic [IDX_W-1:0] idx, logic [HASH_W-1:0] hash,
                                   logic nr);
            path_choice_t c;
            if (pending_choices.size() == 0)
            begin
                flag("unexpected result", '0, hash);
                return;
            end
            c = pending_choices.pop_front();
            if (idx !== c.path_index)
                flag("path_index", HASH_W'(c.path_index), HASH_W'(idx));
            if (hash !== c.hash_value)
                flag("hash_value", c.hash_value, hash);
            if (nr !== c.no_route)
                flag("no_route", HASH_W'(c.no_route), HASH_W'(nr));
            choices++;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [HASH_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    path_choice_tracker board;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold = 0;
    int cycles = 0;
    int seed_settings = 0;

    ecmp_flow_hash_path_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver side: random stall or a long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (sink_hold > 0)
        begin
            m_tready <= 1'b0;
            sink_hold--;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && m_tvalid && m_tready && board != null)
            board.check_choice(m_tdata[IDX_W-1:0], m_tdata[IDX_W +: HASH_W], m_tuser[0]);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    function automatic hdr_t make_hdr(logic [HASH_W-1:0] sa, logic [HASH_W-1:0] da,
                                      logic [PROT_W-1:0] pr, logic [PORT_W-1:0] sp,
                                      logic [PORT_W-1:0] dp, logic [CNT_W-1:0] cnt);
        hdr_t hd;
        hd.src_addr = sa;
        hd.dst_addr = da;
        hd.l3_protocol = pr;
        hd.src_port = sp;
        hd.dst_port = dp;
        hd.path_count = cnt;
        return hd;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_hdr(hdr_t hd);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[IN_BITS-1:0] = {hd.path_count, hd.dst_port, hd.src_port, hd.l3_protocol,
                          hd.dst_addr, hd.src_addr};
        return d;
    endfunction

    function automatic hdr_t random_hdr();
        logic [PROT_W-1:0] pr;
        logic [CNT_W-1:0]  cnt;
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0, 1:    pr = PROTO_TCP;
            2, 3:    pr = PROTO_UDP;
            4:       pr = PROTO_ACK;
            5:       pr = PROTO_NACK;
            default: pr = PROT_W'($urandom_range(255));
        endcase
        sel = $urandom_range(19);
        if (sel == 0)
            cnt = '0;
        else if (sel < 3)
            cnt = CNT_W'($urandom_range(127, MAX_PATHS + 1));
        else
            cnt = CNT_W'($urandom_range(MAX_PATHS, 1));
        return make_hdr($urandom, $urandom, pr, PORT_W'($urandom_range(65535)),
                        PORT_W'($urandom_range(65535)), cnt);
    endfunction

    // entered and left on a falling edge
    task automatic push_request(hdr_t hd);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pack_hdr(hd);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(hd);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_choices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_seed(logic [HASH_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        board.seed = value;
        seed_settings++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(logic [HASH_W-1:0] seed_value, int src_pct, int sink_pct,
                                int hold);
        write_seed(seed_value);
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        sink_hold = hold;
        repeat (ITEMS_PER_PHASE)
            push_request(random_hdr());
        wait_drained();
    endtask

    initial
    begin
        board = new;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part with the reset seed
        push_request(make_hdr('0, '0, '0, '0, '0, '0));
        push_request(make_hdr('1, '1, PROTO_TCP, '1, '1, 7'd1));
        push_request(make_hdr('1, '0, PROTO_UDP, 16'h0000, 16'hffff, 7'd64));
        push_request(make_hdr('0, '1, PROTO_ACK, 16'hffff, 16'h0000, 7'd63));
        push_request(make_hdr(32'hc0a80001, 32'h0a000001, PROTO_NACK, 16'd1234,
                              16'd80, 7'd65));
        push_request(make_hdr(32'hc0a80001, 32'h0a000001, 8'd1, 16'd1234, 16'd80, 7'd127));
        push_request(make_hdr(32'hc0a80001, 32'h0a000001, 8'hff, 16'hffff, 16'hffff, 7'd2));
        push_request(make_hdr(32'hc0a80001, 32'h0a000001, 8'd0, 16'h0000, 16'h0000, 7'd2));
        push_request(make_hdr(32'h12345678, 32'h9abcdef0, 8'd5, 16'd22, 16'd443, 7'd3));
        push_request(make_hdr(32'h12345678, 32'h9abcdef0, 8'd7, 16'd22, 16'd443, 7'd3));
        push_request(make_hdr(32'h12345678, 32'h9abcdef0, 8'd16, 16'd22, 16'd443, 7'd0));
        push_request(make_hdr(32'h12345678, 32'h9abcdef0, 8'd18, 16'd22, 16'd443, 7'd64));
        push_request(make_hdr(32'h12345678, 32'h9abcdef0, 8'd251, 16'd22, 16'd443, 7'd5));
        push_request(make_hdr(32'h12345678, 32'h9abcdef0, 8'd254, 16'd22, 16'd443, 7'd6));
        push_request(make_hdr(32'h80000000, 32'h00000001, PROTO_TCP, 16'h8000, 16'h0001,
                              7'd0));
        push_request(make_hdr(32'h55555555, 32'haaaaaaaa, PROTO_UDP, 16'h5555, 16'haaaa,
                              7'd96));
        push_request(make_hdr(32'haaaaaaaa, 32'h55555555, 8'haa, 16'haaaa, 16'h5555, 7'd42));
        push_request(make_hdr(32'h00000001, 32'h80000000, PROTO_ACK, 16'h0001, 16'h8000,
                              7'd32));
        wait_drained();

        // seed extremes and random seeds over the idling mixes
        random_phase(32'hffffffff, 0, 0, 0);
        random_phase($urandom, 87, 0, 0);
        random_phase(32'h00000000, 0, 87, 0);
        random_phase(32'h80000001, 29, 29, 0);
        random_phase($urandom, 0, 0, 400);

        $display("%0d requests checked over %0d seed settings: %0d results, %0d no route,",
                 board.requests, seed_settings + 1, board.choices, board.dropped);
        $display("%0d without ports, long receiver hold-off with input back-pressure",
                 board.portless);
        if (board.mismatches == 0 && board.pending_choices.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
